// ===== sv/ctkd_pkg.sv =====
// Shared types, field widths and register codes of the capacitive key touch detector.
package ctkd_pkg;

  // Fixed field widths
  localparam int KEY_W   = 4;
  localparam int CT_W    = 12;
  localparam int OM_W    = 12;
  localparam int TM_W    = 16;
  localparam int BASE_W  = 16;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  // Defaults for the top-level parameters
  localparam int DEF_KEY_COUNT  = 16;
  localparam int DEF_WINDOW_LEN = 10;
  localparam int DEF_TIME_BITS  = 12;

  // Register reset values
  localparam logic [OM_W-1:0] OUTLIER_MARGIN_RST = OM_W'(10);
  localparam logic [TM_W-1:0] TOUCH_MARGIN_RST   = TM_W'(90);

  // Baseline saturation value
  localparam logic [BASE_W-1:0] BASE_MAX = '1;

  // Register index, taken from paddr[2]
  localparam logic REG_OUTLIER_MARGIN = 1'b0;
  localparam logic REG_TOUCH_MARGIN   = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CT_W-1:0]  charge_time;
    logic [KEY_W-1:0] selected_key;
  } in_word_t;

  typedef struct packed {
    logic selected_touched;
    logic key_touched;
    logic calibrating;
    logic key_disabled;
  } out_word_t;

  typedef struct packed {
    logic [OM_W-1:0] outlier_margin;
    logic [TM_W-1:0] touch_margin;
  } cfg_t;

endpackage

// ===== sv/ctkd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ctkd_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 160,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/ctkd_cfg.sv =====
// APB-style configuration registers: outlier margin and touch margin.
module ctkd_cfg import ctkd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.outlier_margin <= OUTLIER_MARGIN_RST;
      cfg.touch_margin   <= TOUCH_MARGIN_RST;
    end else if (wr) begin
      unique case (paddr[2])
        REG_OUTLIER_MARGIN: cfg.outlier_margin <= pwdata[OM_W-1:0];
        REG_TOUCH_MARGIN:   cfg.touch_margin   <= pwdata[TM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_OUTLIER_MARGIN: prdata = DATA_W'(cfg.outlier_margin);
      REG_TOUCH_MARGIN:   prdata = DATA_W'(cfg.touch_margin);
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== sv/ctkd_engine.sv =====
// Per-key state and the single-pass calibration / run update for one word.
module ctkd_engine import ctkd_pkg::*; #(
  parameter int KEY_COUNT  = DEF_KEY_COUNT,
  parameter int WINDOW_LEN = DEF_WINDOW_LEN,
  parameter int TIME_BITS  = DEF_TIME_BITS,
  localparam int PTR_W  = $clog2(WINDOW_LEN),
  localparam int ADDR_W = $clog2(KEY_COUNT * WINDOW_LEN)
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              upd,
  input  in_word_t          item,
  input  logic [PTR_W-1:0]  item_ptr,
  input  logic [TIME_BITS-1:0] old_sample,
  input  logic [KEY_W-1:0]  peek_key,
  output logic              peek_ok,
  output logic [PTR_W-1:0]  peek_ptr,
  output logic [ADDR_W-1:0] peek_addr,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [TIME_BITS-1:0] ram_wdata,
  output out_word_t         res
);

  localparam int KEY_IDX_W  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int DONE_W     = $clog2(KEY_COUNT + 1);
  localparam int SUM_W      = TIME_BITS + $clog2(WINDOW_LEN);
  localparam int CMP_W      = (SUM_W > BASE_W + 1) ? SUM_W : BASE_W + 1;
  localparam int OUT_W      = ((TIME_BITS > BASE_W) ? TIME_BITS : BASE_W) + 1;
  localparam int REC_SHIFT  = BASE_W + $clog2(WINDOW_LEN);
  localparam int REC_MULT   = ((1 << REC_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int REC_W      = BASE_W + 1;
  localparam int PROD_W     = BASE_W + REC_W;
  localparam int SEL_DEPTH  = 1 << KEY_W;

  // Per-key state
  logic [SUM_W-1:0]     wsum      [KEY_COUNT];
  logic [SUM_W-1:0]     wsum_next [KEY_COUNT];
  logic [BASE_W-1:0]    base      [KEY_COUNT];
  logic [BASE_W-1:0]    base_next [KEY_COUNT];
  logic [TIME_BITS-1:0] mean      [KEY_COUNT];
  logic [TIME_BITS-1:0] mean_next [KEY_COUNT];
  logic [TIME_BITS-1:0] cmin      [KEY_COUNT];
  logic [TIME_BITS-1:0] cmin_next [KEY_COUNT];
  logic [TIME_BITS-1:0] cmax      [KEY_COUNT];
  logic [TIME_BITS-1:0] cmax_next [KEY_COUNT];
  logic [PTR_W-1:0]     sptr      [KEY_COUNT];
  logic [PTR_W-1:0]     sptr_next [KEY_COUNT];
  logic [KEY_COUNT-1:0] touched, touched_next;
  logic [KEY_COUNT-1:0] disabled, disabled_next;

  // Calibration round state
  logic              in_cal, in_cal_next;
  logic [DONE_W-1:0] keys_done, keys_done_next;
  logic              had, had_next;

  // Selected key modulo key count, constant lookup
  logic [KEY_IDX_W-1:0] sel_tab [SEL_DEPTH];
  for (genvar g = 0; g < SEL_DEPTH; g++) begin : g_sel
    assign sel_tab[g] = KEY_IDX_W'(g % KEY_COUNT);
  end

  logic                 k_ok, do_cal, do_run, last, outlier, had_v, touch_run;
  logic [KEY_IDX_W-1:0] ki, pki, seli;
  logic [TIME_BITS-1:0] t, min_cal, max_cal, tc;
  logic [PTR_W-1:0]     ptr_new;
  logic [SUM_W-1:0]     sum_cal, sum_run;
  logic [BASE_W-1:0]    base_cal, mean_cal;
  logic [PROD_W-1:0]    prod;

  assign k_ok = 32'(item.key) < KEY_COUNT;
  assign ki   = KEY_IDX_W'(item.key);
  assign t    = TIME_BITS'(item.charge_time);
  assign last = item_ptr == PTR_W'(WINDOW_LEN - 1);
  assign ptr_new = last ? '0 : PTR_W'(item_ptr + 1'b1);

  assign do_cal = upd & k_ok & in_cal & (32'(item.key) == 32'(keys_done));
  assign do_run = upd & k_ok & ~in_cal & ~disabled[ki];

  // Calibration: running sum, min and max
  assign sum_cal = (item_ptr == '0) ? SUM_W'(t) : SUM_W'(wsum[ki] + SUM_W'(t));
  assign min_cal = ((item_ptr == '0) || (t < cmin[ki])) ? t : cmin[ki];
  assign max_cal = ((item_ptr == '0) || (t > cmax[ki])) ? t : cmax[ki];
  assign base_cal = (CMP_W'(sum_cal) > CMP_W'(BASE_MAX)) ? BASE_MAX : BASE_W'(sum_cal);

  // Exact divide by window length through reciprocal multiply
  assign prod     = PROD_W'(base_cal) * PROD_W'(REC_MULT);
  assign mean_cal = BASE_W'(prod >> REC_SHIFT);

  assign outlier =
    (OUT_W'(max_cal) >= OUT_W'(mean_cal) + OUT_W'(cfg.outlier_margin)) ||
    (OUT_W'(min_cal) + OUT_W'(cfg.outlier_margin) <= OUT_W'(mean_cal));
  assign had_v = had | outlier;

  // Run: clamp to mean, slide the window
  assign tc        = (t < mean[ki]) ? mean[ki] : t;
  assign sum_run   = SUM_W'(wsum[ki] - SUM_W'(old_sample) + SUM_W'(tc));
  assign touch_run = CMP_W'(sum_run) >= CMP_W'(base[ki]) + CMP_W'(cfg.touch_margin);

  always_comb begin
    wsum_next      = wsum;
    base_next      = base;
    mean_next      = mean;
    cmin_next      = cmin;
    cmax_next      = cmax;
    sptr_next      = sptr;
    touched_next   = touched;
    disabled_next  = disabled;
    in_cal_next    = in_cal;
    keys_done_next = keys_done;
    had_next       = had;
    if (do_cal) begin
      wsum_next[ki] = sum_cal;
      cmin_next[ki] = min_cal;
      cmax_next[ki] = max_cal;
      sptr_next[ki] = ptr_new;
      if (last) begin
        base_next[ki] = base_cal;
        mean_next[ki] = TIME_BITS'(mean_cal);
        if (32'(keys_done) + 1 >= KEY_COUNT) begin
          keys_done_next = '0;
          had_next       = 1'b0;
          if (!had_v) begin
            in_cal_next = 1'b0;
            for (int j = 0; j < KEY_COUNT; j++) begin
              disabled_next[j] = base_next[j] == '0;
            end
          end
        end else begin
          keys_done_next = DONE_W'(keys_done + 1'b1);
          had_next       = had_v;
        end
      end
    end
    if (do_run) begin
      wsum_next[ki]    = sum_run;
      sptr_next[ki]    = ptr_new;
      touched_next[ki] = touch_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < KEY_COUNT; j++) begin
        wsum[j] <= '0;
        base[j] <= '0;
        mean[j] <= '0;
        cmin[j] <= '1;
        cmax[j] <= '0;
        sptr[j] <= '0;
      end
      touched   <= '0;
      disabled  <= '0;
      in_cal    <= 1'b1;
      keys_done <= '0;
      had       <= 1'b0;
    end else begin
      wsum      <= wsum_next;
      base      <= base_next;
      mean      <= mean_next;
      cmin      <= cmin_next;
      cmax      <= cmax_next;
      sptr      <= sptr_next;
      touched   <= touched_next;
      disabled  <= disabled_next;
      in_cal    <= in_cal_next;
      keys_done <= keys_done_next;
      had       <= had_next;
    end
  end

  // Window RAM write
  assign ram_we    = do_cal | do_run;
  assign ram_waddr = ADDR_W'(ADDR_W'(ki) * ADDR_W'(WINDOW_LEN) + ADDR_W'(item_ptr));
  assign ram_wdata = do_cal ? t : tc;

  // Slot lookup for the incoming word, forwarding this word's pointer update
  assign peek_ok  = 32'(peek_key) < KEY_COUNT;
  assign pki      = KEY_IDX_W'(peek_key);
  assign peek_ptr = (ram_we && (peek_key == item.key)) ? ptr_new : sptr[pki];
  assign peek_addr = ADDR_W'(ADDR_W'(pki) * ADDR_W'(WINDOW_LEN) + ADDR_W'(peek_ptr));

  // Result from post-update state
  assign seli = sel_tab[item.selected_key];
  assign res.selected_touched = touched_next[seli];
  assign res.key_touched      = k_ok & touched_next[ki];
  assign res.calibrating      = in_cal_next;
  assign res.key_disabled     = k_ok & disabled_next[ki];

  a_done_range: assert property (@(posedge clk) disable iff (rst)
    32'(keys_done) < KEY_COUNT)
    else $error("calibration key counter out of range");

  a_run_clean: assert property (@(posedge clk) disable iff (rst)
    !in_cal |-> (keys_done == '0) && !had)
    else $error("round state not cleared after calibration");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    peek_ok |-> 32'(peek_ptr) < WINDOW_LEN)
    else $error("slot pointer beyond window");

endmodule

// ===== sv/capacitive_key_touch_detector_unit.sv =====
// Top level of the capacitive key touch detector: handshake, staging and instances.
//
// One sample word per cycle, sustained while the result channel is not stalled:
// the word is registered together with the window slot read from the sample RAM,
// the whole key update (calibration sum/min/max and outlier check, or run-mode
// clamp, window slide and touch compare) runs in one pass, and the result lands
// in the output register. The window RAM has a single read port; the
// slot pointer of a key hit twice in a row is forwarded so the read is always
// the correct oldest slot. After reset the block calibrates: keys must arrive in
// order 0..KEY_COUNT-1, each with WINDOW_LEN samples, and a round with no
// outlier ends calibration; samples for any other key are dropped but still
// answered. The window RAM needs no clearing pass, since calibration fills
// every slot before run mode reads it. Margins are written through the APB
// port while idle: offset 0 outlier margin, offset 4 touch margin.
module capacitive_key_touch_detector_unit import ctkd_pkg::*; #(
  parameter int KEY_COUNT  = DEF_KEY_COUNT,
  parameter int WINDOW_LEN = DEF_WINDOW_LEN,
  parameter int TIME_BITS  = DEF_TIME_BITS
) (
  input  logic               clk,
  input  logic               rst,
  // sample channel
  input  logic               sample_valid,
  output logic               sample_stall,
  input  in_word_t           sample,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output out_word_t          result,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int PTR_W  = $clog2(WINDOW_LEN);
  localparam int DEPTH  = KEY_COUNT * WINDOW_LEN;
  localparam int ADDR_W = $clog2(DEPTH);

  cfg_t cfg;

  // Stage 1: accepted word and its slot
  logic              s1_valid;
  in_word_t          s1_item;
  logic [PTR_W-1:0]  s1_ptr;
  logic              s1_move, accept;

  logic                 peek_ok, ram_we;
  logic [PTR_W-1:0]     peek_ptr;
  logic [ADDR_W-1:0]    peek_addr, ram_waddr;
  logic [TIME_BITS-1:0] ram_wdata, old_sample;
  out_word_t            eng_res;

  // Stage 1 drains into the output register when that is free or being taken
  assign s1_move      = s1_valid & (~result_valid | ~result_stall);
  assign sample_stall = s1_valid & ~s1_move;
  assign accept       = sample_valid & ~sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= sample;
      s1_ptr  <= peek_ptr;
    end
    if (s1_move) begin
      result <= eng_res;
    end
  end

  ctkd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sample window: one entry per key and slot, read as the word is accepted
  ctkd_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept & peek_ok),
    .raddr (peek_addr),
    .rdata (old_sample)
  );

  ctkd_engine #(
    .KEY_COUNT  (KEY_COUNT),
    .WINDOW_LEN (WINDOW_LEN),
    .TIME_BITS  (TIME_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .upd        (s1_move),
    .item       (s1_item),
    .item_ptr   (s1_ptr),
    .old_sample (old_sample),
    .peek_key   (sample.key),
    .peek_ok    (peek_ok),
    .peek_ptr   (peek_ptr),
    .peek_addr  (peek_addr),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .res        (eng_res)
  );

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_item) && $stable(s1_ptr))
    else $error("stage 1 word lost while output blocked");

  a_cal_no_touch: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.calibrating |-> !result.selected_touched && !result.key_touched)
    else $error("touch reported during calibration");

  a_disabled_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.key_disabled |-> !result.calibrating && !result.key_touched)
    else $error("disabled key reported touched or during calibration");

endmodule
